>>> src/opcbp_pkg.sv
package opcbp_pkg;

  // Widest field the datapath supports; the accumulator holds one field
  // plus up to seven leftover bits.
  localparam int MAX_FIELD_BITS = 24;
  localparam int FW             = MAX_FIELD_BITS;
  localparam int ACC_W          = MAX_FIELD_BITS + 7;
  localparam int CNT_W          = $clog2(ACC_W + 1);
  localparam int CB_W           = 5;
  localparam int COEFF_W        = 24;
  localparam int BYTE_W         = 8;
  localparam int NRES_W         = 3;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = CB_W;
  localparam int JOBQ_DEPTH     = 2;
  localparam int JOBQ_PTR_W     = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CNT_W     = $clog2(JOBQ_DEPTH + 1);

  localparam logic [CB_W-1:0] COEFF_BITS_RESET = CB_W'(8);
  localparam logic [CB_W-1:0] MIN_FIELD        = CB_W'(2);
  localparam logic [CB_W-1:0] MAX_FIELD        = CB_W'(MAX_FIELD_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION  = 2'd0,
    CFG_COEFF_BITS = 2'd1
  } cfg_idx_t;

  // Active configuration as seen by the datapath.
  typedef struct packed {
    logic            unpack;
    logic [CB_W-1:0] field_w;
  } cfg_t;

  // One classified word: merged stream bits and how many results they give.
  typedef struct packed {
    logic [ACC_W-1:0]  acc;
    logic [NRES_W-1:0] nres;
  } job_t;

  typedef struct packed {
    logic [CNT_W-1:0] pend;
  } front_stat_t;

  typedef struct packed {
    logic              busy;
    logic [NRES_W-1:0] left;
  } back_stat_t;

  function automatic logic [CB_W-1:0] clamp_width(input logic [CB_W-1:0] cb);
    logic [CB_W-1:0] w;
    w = cb;
    if (cb < MIN_FIELD) begin
      w = MIN_FIELD;
    end else if (cb > MAX_FIELD) begin
      w = MAX_FIELD;
    end
    return w;
  endfunction

  // Low-order mask of a field of the given width.
  function automatic logic [FW-1:0] field_mask(input logic [CB_W-1:0] w);
    return ~({FW{1'b1}} << w);
  endfunction

endpackage

>>> src/offset_coeff_bit_pack_unpack_top.sv
// A word accepted on an idle block goes through the job queue and the emit stage's
// work register before its first result reaches the output ports; further results
// of that word follow one per cycle while the receiver pops. Throughput: one result
// word per cycle while popped, set by the single output register of the emit stage.
// Reset (rst_n low, synchronous) empties the job queue and output register and sets
// pack mode, an 8-bit field width and an empty bit accumulator.
module offset_coeff_bit_pack_unpack_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic [opcbp_pkg::COEFF_W-1:0]    in_coeff_in,
  input  logic [opcbp_pkg::BYTE_W-1:0]     in_byte_in,
  input  logic                             in_end_of_poly,
  output logic                             empty,
  input  logic                             pop,
  output logic [opcbp_pkg::BYTE_W-1:0]     out_byte_out,
  output logic [opcbp_pkg::COEFF_W-1:0]    out_coeff_out,
  output logic                             out_last_of_run,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [opcbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [opcbp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import opcbp_pkg::*;

  // Configuration registers. Writes are only expected while the block is idle,
  // so the datapath reads them directly without shadow copies.
  logic            dir_r, dir_nxt;
  logic [CB_W-1:0] cb_r, cb_nxt;
  logic            cfg_clear;
  cfg_t            cfg;

  // Front to queue to back.
  logic        accept;
  logic        job_push;
  job_t        job_in, job_out;
  logic        q_empty, q_full, q_pop;
  front_stat_t fstat;
  back_stat_t  bstat;

  assign cfg_ready = 1'b1;

  // Any write to a known register also flushes the bit accumulator, so a
  // polynomial never straddles a mode or width change.
  always_comb begin
    dir_nxt   = dir_r;
    cb_nxt    = cb_r;
    cfg_clear = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DIRECTION: begin
          dir_nxt   = cfg_wdata[0];
          cfg_clear = 1'b1;
        end
        CFG_COEFF_BITS: begin
          cb_nxt    = cfg_wdata;
          cfg_clear = 1'b1;
        end
        default: begin
          cfg_clear = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
      cb_r  <= COEFF_BITS_RESET;
    end else begin
      dir_r <= dir_nxt;
      cb_r  <= cb_nxt;
    end
  end

  assign cfg.unpack  = dir_r;
  assign cfg.field_w = clamp_width(cb_r);

  // The front merges each word into the accumulator in the cycle it is
  // accepted and hands the merged bits to the queue, so it only waits when the
  // queue is full.
  assign full   = q_full;
  assign accept = push && !q_full;

  opcbp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear       (cfg_clear),
    .accept      (accept),
    .cfg         (cfg),
    .coeff_in    (in_coeff_in),
    .byte_in     (in_byte_in),
    .end_of_poly (in_end_of_poly),
    .job_push    (job_push),
    .job         (job_in),
    .stat        (fstat)
  );

  opcbp_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_job  (job_in),
    .rd_en   (q_pop),
    .rd_job  (job_out),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  // While the output register is free or popped, the back stage slices one byte
  // or one field per cycle out of the queued bits and holds it until popped.
  opcbp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .q_job       (job_out),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .byte_out    (out_byte_out),
    .coeff_out   (out_coeff_out),
    .last_of_run (out_last_of_run),
    .stat        (bstat)
  );

  // Leftover bits never reach a whole byte in pack mode.
  a_pack_leftover: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg.unpack |-> (fstat.pend < CNT_W'(BYTE_W)))
    else $error("pack leftover count reached a full byte");

  // Leftover bits never reach a whole field in unpack mode.
  a_unpack_leftover: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.unpack |-> (fstat.pend < cfg.field_w))
    else $error("unpack leftover count reached a full field");

  // The end of a polynomial empties the accumulator.
  a_eop_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_end_of_poly) |=> (fstat.pend == '0))
    else $error("accumulator not flushed after end of polynomial");

  // A busy emit stage always has results left to send.
  a_busy_left: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.busy |-> (bstat.left != '0))
    else $error("emit stage busy with no results left");

endmodule

>>> src/opcbp_front.sv
module opcbp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clear,
  input  logic                          accept,
  input  opcbp_pkg::cfg_t               cfg,
  input  logic [opcbp_pkg::COEFF_W-1:0] coeff_in,
  input  logic [opcbp_pkg::BYTE_W-1:0]  byte_in,
  input  logic                          end_of_poly,
  output logic                          job_push,
  output opcbp_pkg::job_t               job,
  output opcbp_pkg::front_stat_t        stat
);
  import opcbp_pkg::*;

  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0]  pend_r, pend_nxt;
  logic [FW-1:0]     mask, offset, code;
  logic [ACC_W-1:0]  merged;
  logic [CNT_W-1:0]  total, consumed;
  logic [CNT_W+1:0]  tot_x, b1, b2, b3, b4;
  logic [NRES_W-1:0] nres;

  assign mask   = field_mask(cfg.field_w);
  assign offset = mask >> 1;
  assign code   = (offset - coeff_in[FW-1:0]) & mask;

  assign tot_x = {2'b00, total};
  assign b1    = {2'b00, cfg.field_w};
  assign b2    = b1 << 1;
  assign b3    = b1 + b2;
  assign b4    = b1 << 2;

  always_comb begin
    if (cfg.unpack) begin
      merged = acc_r | (ACC_W'(byte_in) << pend_r);
      total  = pend_r + CNT_W'(BYTE_W);
      nres   = NRES_W'(tot_x >= b1) + NRES_W'(tot_x >= b2) +
               NRES_W'(tot_x >= b3) + NRES_W'(tot_x >= b4);
      unique case (nres)
        3'd0:    consumed = '0;
        3'd1:    consumed = CNT_W'(b1);
        3'd2:    consumed = CNT_W'(b2);
        3'd3:    consumed = CNT_W'(b3);
        default: consumed = CNT_W'(b4);
      endcase
    end else begin
      merged   = acc_r | (ACC_W'(code) << pend_r);
      total    = pend_r + cfg.field_w;
      nres     = NRES_W'(total >> 3);
      consumed = CNT_W'({nres, 3'b000});
    end
  end

  always_comb begin
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    if (clear) begin
      acc_nxt  = '0;
      pend_nxt = '0;
    end else if (accept) begin
      if (end_of_poly) begin
        acc_nxt  = '0;
        pend_nxt = '0;
      end else begin
        acc_nxt  = merged >> consumed;
        pend_nxt = total - consumed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pend_r <= '0;
    end else begin
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
    end
  end

  assign job_push  = accept && (nres != '0);
  assign job.acc   = merged;
  assign job.nres  = nres;
  assign stat.pend = pend_r;

endmodule

>>> src/opcbp_jobq.sv
module opcbp_jobq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  opcbp_pkg::job_t wr_job,
  input  logic            rd_en,
  output opcbp_pkg::job_t rd_job,
  output logic            q_empty,
  output logic            q_full
);
  import opcbp_pkg::*;

  job_t                  slot_r [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [JOBQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [JOBQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  do_wr, do_rd;

  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign q_empty = (cnt_r == '0);
  assign q_full  = (cnt_r == JOBQ_CNT_W'(JOBQ_DEPTH));
  assign rd_job  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

>>> src/opcbp_back.sv
module opcbp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  opcbp_pkg::cfg_t               cfg,
  input  logic                          q_empty,
  input  opcbp_pkg::job_t               q_job,
  output logic                          q_pop,
  input  logic                          pop,
  output logic                          empty,
  output logic [opcbp_pkg::BYTE_W-1:0]  byte_out,
  output logic [opcbp_pkg::COEFF_W-1:0] coeff_out,
  output logic                          last_of_run,
  output opcbp_pkg::back_stat_t         stat
);
  import opcbp_pkg::*;

  logic                busy_r, busy_nxt;
  logic [ACC_W-1:0]    work_r, work_nxt;
  logic [NRES_W-1:0]   left_r, left_nxt;
  logic                ovld_r, ovld_nxt;
  logic [BYTE_W-1:0]   byte_r;
  logic [COEFF_W-1:0]  coeff_r;
  logic                last_r;
  logic                emit, finish;
  logic [FW-1:0]       mask, offset, field;
  logic [BYTE_W-1:0]   emit_byte;
  logic [COEFF_W-1:0]  emit_coeff;

  assign mask   = field_mask(cfg.field_w);
  assign offset = mask >> 1;
  assign field  = work_r[FW-1:0] & mask;

  // One result per cycle whenever the output register is free or drains.
  assign emit   = busy_r && (!ovld_r || pop);
  assign finish = emit && (left_r == NRES_W'(1));
  assign q_pop  = !q_empty && (!busy_r || finish);

  assign emit_byte  = cfg.unpack ? '0 : work_r[BYTE_W-1:0];
  assign emit_coeff = cfg.unpack ? (COEFF_W'(offset) - COEFF_W'(field)) : '0;

  always_comb begin
    busy_nxt = busy_r;
    work_nxt = work_r;
    left_nxt = left_r;
    ovld_nxt = ovld_r;
    if (pop) begin
      ovld_nxt = 1'b0;
    end
    if (emit) begin
      ovld_nxt = 1'b1;
      left_nxt = left_r - 1'b1;
      work_nxt = cfg.unpack ? (work_r >> cfg.field_w) : (work_r >> BYTE_W);
      if (finish) begin
        busy_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      work_nxt = q_job.acc;
      left_nxt = q_job.nres;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      left_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      left_r <= left_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    if (emit) begin
      byte_r  <= emit_byte;
      coeff_r <= emit_coeff;
      last_r  <= finish;
    end
  end

  assign empty       = !ovld_r;
  assign byte_out    = byte_r;
  assign coeff_out   = coeff_r;
  assign last_of_run = last_r;
  assign stat.busy   = busy_r;
  assign stat.left   = left_r;

endmodule

>>> bench/opcbp_checker.sv
`timescale 1ns / 100ps

module opcbp_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  logic                             full,
  input  logic [opcbp_pkg::COEFF_W-1:0]    in_coeff_in,
  input  logic [opcbp_pkg::BYTE_W-1:0]     in_byte_in,
  input  logic                             in_end_of_poly,
  input  logic                             empty,
  input  logic                             pop,
  input  logic [opcbp_pkg::BYTE_W-1:0]     out_byte_out,
  input  logic [opcbp_pkg::COEFF_W-1:0]    out_coeff_out,
  input  logic                             out_last_of_run,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [opcbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [opcbp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                               fail_count,
  output int                               pending_words
);

  localparam int          REPORT_LIMIT = 10;
  localparam int unsigned STREAM_MASK  = 32'h7fff_ffff;

  typedef struct packed {
    logic [opcbp_pkg::BYTE_W-1:0]  octet;
    logic [opcbp_pkg::COEFF_W-1:0] coeff;
    logic                          last;
  } stream_word_t;

  stream_word_t expected_q[$];

  logic                          unpack_mode;
  logic [opcbp_pkg::CB_W-1:0]    width_reg;
  int unsigned                   stream_bits;
  int unsigned                   bit_count;

  // Appends one input word to the bit stream and queues every complete
  // byte (packing) or field (unpacking) that it finishes.
  task automatic convert_word(input logic [opcbp_pkg::COEFF_W-1:0] coeff,
                              input logic [opcbp_pkg::BYTE_W-1:0] octet,
                              input logic eop);
    stream_word_t made [4];
    int unsigned  w;
    int unsigned  mask;
    int unsigned  offs;
    int unsigned  field;
    int           n;
    w = (width_reg < 2) ? 2 : ((width_reg > opcbp_pkg::MAX_FIELD_BITS) ?
        opcbp_pkg::MAX_FIELD_BITS : int'(width_reg));
    mask = (32'd1 << w) - 32'd1;
    offs = (32'd1 << (w - 1)) - 32'd1;
    n = 0;
    if (!unpack_mode) begin
      field = (offs - 32'(coeff)) & mask;
      stream_bits = (stream_bits | (field << bit_count)) & STREAM_MASK;
      bit_count = bit_count + w;
      while (bit_count >= 8 && n < 4) begin
        made[n] = '{octet: stream_bits[7:0], coeff: '0, last: 1'b0};
        stream_bits = stream_bits >> 8;
        bit_count = bit_count - 8;
        n++;
      end
    end else begin
      stream_bits = (stream_bits | (32'(octet) << bit_count)) & STREAM_MASK;
      bit_count = bit_count + 8;
      while (bit_count >= w && n < 4) begin
        field = (offs - (stream_bits & mask)) & 32'h00ff_ffff;
        made[n] = '{octet: '0, coeff: field[23:0], last: 1'b0};
        stream_bits = stream_bits >> w;
        bit_count = bit_count - w;
        n++;
      end
    end
    bit_count = bit_count & 32'h1f;
    if (n > 0) begin
      made[n-1].last = 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      expected_q.push_back(made[k]);
    end
    if (eop) begin
      stream_bits = 0;
      bit_count = 0;
    end
  endtask

  always @(posedge clk) begin : monitor
    stream_word_t want;
    if (!rst_n) begin
      unpack_mode = 1'b0;
      width_reg = opcbp_pkg::COEFF_BITS_RESET;
      stream_bits = 0;
      bit_count = 0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: unexpected word: byte %h coeff %h last %b", $time,
                     out_byte_out, out_coeff_out, out_last_of_run);
          end
        end else begin
          want = expected_q.pop_front();
          if (want.octet !== out_byte_out || want.coeff !== out_coeff_out ||
              want.last !== out_last_of_run) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("%0t: mismatch: expected byte %h coeff %h last %b, got byte %h coeff %h last %b",
                       $time, want.octet, want.coeff, want.last,
                       out_byte_out, out_coeff_out, out_last_of_run);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == opcbp_pkg::CFG_DIRECTION) begin
          unpack_mode = cfg_wdata[0];
          stream_bits = 0;
          bit_count = 0;
        end else if (cfg_index == opcbp_pkg::CFG_COEFF_BITS) begin
          width_reg = cfg_wdata;
          stream_bits = 0;
          bit_count = 0;
        end
      end
      if (push && !full) begin
        convert_word(in_coeff_in, in_byte_in, in_end_of_poly);
      end
    end
    pending_words = expected_q.size();
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;

  // The run is bounded by a cycle counter; this is far above the slowest
  // correct run even with the long receiver hold-offs.
  localparam int CYCLE_LIMIT  = 400000;
  // Cycles to let pass after the last expected word before touching the
  // configuration, since a word may still be in flight without a result.
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 10;
  localparam int PHASE_WORDS   = 48;

  localparam logic [opcbp_pkg::CFG_DATA_W-1:0] DIR_PACK   = 5'd0;
  localparam logic [opcbp_pkg::CFG_DATA_W-1:0] DIR_UNPACK = 5'd1;

  // An index that maps to no register; writing it must change nothing.
  localparam opcbp_pkg::cfg_idx_t CFG_SPARE = opcbp_pkg::cfg_idx_t'(2'd3);

  // Field widths of the random phases, extremes and out-of-range codes first.
  localparam logic [4:0] PHASE_WIDTHS [8] = '{5'd2, 5'd24, 5'd1, 5'd31,
                                              5'd24, 5'd8, 5'd0, 5'd25};

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             push = 1'b0;
  logic                             full;
  logic [opcbp_pkg::COEFF_W-1:0]    in_coeff_in = '0;
  logic [opcbp_pkg::BYTE_W-1:0]     in_byte_in = '0;
  logic                             in_end_of_poly = 1'b0;
  logic                             empty;
  logic                             pop = 1'b0;
  logic [opcbp_pkg::BYTE_W-1:0]     out_byte_out;
  logic [opcbp_pkg::COEFF_W-1:0]    out_coeff_out;
  logic                             out_last_of_run;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  opcbp_pkg::cfg_idx_t              cfg_index = opcbp_pkg::CFG_DIRECTION;
  logic [opcbp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int pending_words;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // The stimulus bumps hold_req to ask for a long receiver hold-off; the
  // receiver process notices the change and counts the stretch itself.
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  offset_coeff_bit_pack_unpack_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_coeff_in     (in_coeff_in),
    .in_byte_in      (in_byte_in),
    .in_end_of_poly  (in_end_of_poly),
    .empty           (empty),
    .pop             (pop),
    .out_byte_out    (out_byte_out),
    .out_coeff_out   (out_coeff_out),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // The checker sees the same edges as the block and predicts every word.
  opcbp_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_coeff_in     (in_coeff_in),
    .in_byte_in      (in_byte_in),
    .in_end_of_poly  (in_end_of_poly),
    .empty           (empty),
    .pop             (pop),
    .out_byte_out    (out_byte_out),
    .out_coeff_out   (out_coeff_out),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_words   (pending_words)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: pops at random according to the current stall rate, except
  // during a requested hold-off, when pop stays low until the HOLD_CYCLES count runs out.
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= (rst_n && $urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 69;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 69;
      end
      default: begin
        send_idle_pct = 16;
        recv_stall_pct = 16;
      end
    endcase
  endtask

  // Offers one word from the next falling edge on and returns at the rising
  // edge that accepts it. push stays high so a following word can go out
  // back to back; wait_idle lowers it.
  task automatic send_word(input logic [opcbp_pkg::COEFF_W-1:0] coeff,
                           input logic [opcbp_pkg::BYTE_W-1:0] octet,
                           input logic eop);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_coeff_in <= coeff;
    in_byte_in <= octet;
    in_end_of_poly <= eop;
    do @(posedge clk); while (full);
  endtask

  // Stops offering words, waits until every predicted word has come out,
  // then lets the pipeline settle so no word is still being worked on.
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input opcbp_pkg::cfg_idx_t idx,
                           input logic [opcbp_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sends polynomials with random content. Most of them are well formed,
  // ending on exactly one end-of-polynomial word; the rest scatter the mark
  // at random so leftover bits get dropped at odd points.
  task automatic run_phase(input int words);
    int                            sent;
    int                            len;
    logic                          noisy;
    logic [opcbp_pkg::COEFF_W-1:0] coeff;
    logic                          eop;
    sent = 0;
    while (sent < words) begin
      len = $urandom_range(1, 12);
      // The last polynomial of a phase is cut short to hit the word count.
      if (len > words - sent) begin
        len = words - sent;
      end
      noisy = ($urandom_range(99) < 15);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(7))
          0: coeff = 24'h7f_ffff;
          1: coeff = 24'h80_0000;
          default: coeff = 24'($urandom);
        endcase
        eop = noisy ? 1'($urandom_range(1)) : (k == len - 1);
        send_word(coeff, 8'($urandom), eop);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [4:0] width;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_idling(IDLE_BOTH);

    // Reset defaults: packing with 8-bit fields, field extremes.
    send_word(24'h00_0000, 8'h00, 1'b0);
    send_word(24'h7f_ffff, 8'hff, 1'b0);
    send_word(24'h80_0000, 8'h00, 1'b0);
    send_word(24'hff_ffff, 8'h5a, 1'b1);
    wait_idle();

    // Widest field: three bytes per coefficient.
    write_reg(opcbp_pkg::CFG_COEFF_BITS, 5'd24);
    send_word(24'h7f_ffff, 8'h00, 1'b0);
    send_word(24'h80_0000, 8'hff, 1'b0);
    send_word(24'h5a_5a5a, 8'h00, 1'b1);
    wait_idle();

    // 3-bit fields: nine bits give one byte, the last bit is dropped.
    write_reg(opcbp_pkg::CFG_COEFF_BITS, 5'd3);
    send_word(24'h00_0001, 8'h00, 1'b0);
    send_word(24'hff_fffc, 8'h00, 1'b0);
    send_word(24'h00_0005, 8'h00, 1'b1);
    wait_idle();

    // Unpacking 2-bit fields: four coefficients per byte.
    write_reg(opcbp_pkg::CFG_DIRECTION, DIR_UNPACK);
    write_reg(opcbp_pkg::CFG_COEFF_BITS, 5'd2);
    send_word(24'h7f_ffff, 8'h00, 1'b0);
    send_word(24'h80_0000, 8'hff, 1'b0);
    send_word(24'h00_0000, 8'ha5, 1'b1);
    wait_idle();

    // Unpacking 24-bit fields; the two trailing bytes never complete a field.
    write_reg(opcbp_pkg::CFG_COEFF_BITS, 5'd24);
    send_word(24'h00_0000, 8'h00, 1'b0);
    send_word(24'h00_0000, 8'hff, 1'b0);
    send_word(24'h00_0000, 8'h12, 1'b0);
    send_word(24'h00_0000, 8'h80, 1'b0);
    send_word(24'h00_0000, 8'h7f, 1'b1);
    wait_idle();

    // A width code below the minimum behaves as 2 bits.
    write_reg(opcbp_pkg::CFG_COEFF_BITS, 5'd0);
    send_word(24'h00_0000, 8'h3c, 1'b1);
    wait_idle();

    // A write to an unused index must keep the leftover bits of the stream.
    write_reg(opcbp_pkg::CFG_COEFF_BITS, 5'd5);
    send_word(24'h00_0000, 8'hff, 1'b0);
    wait_idle();
    write_reg(CFG_SPARE, 5'd31);
    send_word(24'h00_0000, 8'h0f, 1'b1);
    wait_idle();

    // A width code above the maximum behaves as 24 bits.
    write_reg(opcbp_pkg::CFG_DIRECTION, DIR_PACK);
    write_reg(opcbp_pkg::CFG_COEFF_BITS, 5'd31);
    send_word(24'h12_3456, 8'h00, 1'b1);
    wait_idle();

    // Rewriting the same width mid-polynomial still clears the stream.
    write_reg(opcbp_pkg::CFG_COEFF_BITS, 5'd5);
    send_word(24'h00_0003, 8'h00, 1'b0);
    wait_idle();
    write_reg(opcbp_pkg::CFG_COEFF_BITS, 5'd5);
    send_word(24'h00_001f, 8'h00, 1'b0);
    send_word(24'h00_000a, 8'h00, 1'b1);
    wait_idle();

    // Random phases, alternating direction and cycling the idling patterns.
    // Two packing phases start with a long receiver hold-off while words keep
    // coming, so the block fills up and has to push back.
    for (int p = 0; p < PHASES; p++) begin
      width = (p < 8) ? PHASE_WIDTHS[p] : 5'($urandom_range(3, 23));
      write_reg(opcbp_pkg::CFG_COEFF_BITS, width);
      write_reg(opcbp_pkg::CFG_DIRECTION, (p % 2 == 0) ? DIR_PACK : DIR_UNPACK);
      set_idling(idle_mode_t'(p % 4));
      if (p == 4 || p == 8) begin
        hold_req = hold_req + 1;
      end
      run_phase(PHASE_WORDS);
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
src/opcbp_pkg.sv
src/opcbp_front.sv
src/opcbp_jobq.sv
src/opcbp_back.sv
src/offset_coeff_bit_pack_unpack_top.sv
bench/opcbp_checker.sv
bench/tb.sv
